FILE: hdl/u8tok_pkg.sv
// shared types, constants and decode helpers for the utf8 phoneme tokenizer
package u8tok_pkg;

	// default sizes
	localparam int DEF_MAP_ENTRIES  = 8960;
	localparam int DEF_TOKEN_CAP    = 4096;
	localparam int DEF_SYMBOL_COUNT = 256;

	// fixed widths
	localparam int CP_W           = 21;
	localparam int CMD_ADDR_W     = 16;
	localparam int ENTRY_W        = 9;
	localparam int CMD_FIFO_DEPTH = 4;

	// map entry with the unmapped flag in the top bit
	localparam logic [ENTRY_W-1:0] NO_TOKEN   = 9'h100;
	localparam logic [7:0]         PAD_ID     = 8'd0;
	localparam logic [7:0]         NEWLINE_ID = 8'd10;

	// input operation codes
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_BYTE   = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	// commands from the front to the back
	typedef enum logic [2:0] {
		CMD_LOAD,
		CMD_PAD,
		CMD_LOOKUP,
		CMD_TERM,
		CMD_NL,
		CMD_END
	} cmd_kind_t;

	// front sequencer states
	typedef enum logic [2:0] {
		FS_IDLE,
		FS_BYTE,
		FS_FIN1,
		FS_FIN2,
		FS_TERM,
		FS_NL,
		FS_END
	} front_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] map_code_point;
		logic [7:0]  map_symbol_id;
		logic [7:0]  text_byte;
		logic [7:0]  terminator_char;
	} tok_in_t;

	typedef struct packed {
		logic [7:0] token_id;
		logic       sentence_end;
	} tok_out_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [CMD_ADDR_W-1:0] addr;
		logic [7:0]            sym;
	} cmd_t;

	// sequence length from a lead byte, zero for a bad lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (b < 8'h80) begin
			len = 3'd1;
		end else if (b inside {[8'hC0:8'hDF]}) begin
			len = 3'd2;
		end else if (b inside {[8'hE0:8'hEF]}) begin
			len = 3'd3;
		end else if (b inside {[8'hF0:8'hF7]}) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	// code point from a lead, middle bytes and the final byte
	function automatic logic [CP_W-1:0] cp_from_seq(input logic [2:0] len,
		input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
		input logic [7:0] last);
		logic [CP_W-1:0] cp;
		case (len)
			3'd2: cp = {10'd0, b0[4:0], last[5:0]};
			3'd3: cp = {5'd0, b0[3:0], b1[5:0], last[5:0]};
			3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], last[5:0]};
			default: cp = {13'd0, b0};
		endcase
		return cp;
	endfunction

endpackage

FILE: hdl/u8tok_ram.sv
// generic single-write, single-read ram with registered read data
module u8tok_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 8960
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hdl/u8tok_fifo.sv
// short command queue between the front and the back
module u8tok_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u8tok_pkg::cmd_t  push_cmd,
	output logic             full,
	input  logic             pop,
	output u8tok_pkg::cmd_t  head,
	output logic             empty
);
	import u8tok_pkg::*;

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             slot_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(CMD_FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

FILE: hdl/u8tok_front.sv
// front end: accepts items, decodes utf8 and issues commands
module u8tok_front #(
	parameter int MAP_ENTRIES  = u8tok_pkg::DEF_MAP_ENTRIES,
	parameter int SYMBOL_COUNT = u8tok_pkg::DEF_SYMBOL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               map_ready,
	input  logic               in_valid,
	output logic               in_ready,
	input  u8tok_pkg::tok_in_t in_item,
	output logic               push,
	output u8tok_pkg::cmd_t    push_cmd,
	input  logic               q_full
);
	import u8tok_pkg::*;

	localparam logic [31:0] MAP_LIMIT = 32'(MAP_ENTRIES);
	localparam logic [8:0]  SYM_LIMIT = 9'(SYMBOL_COUNT);

	front_state_t state_q, state_d;
	logic         open_q, open_d;
	logic [2:0]   seq_q, seq_d;
	logic [1:0]   cnt_q, cnt_d;
	logic [7:0]   pend0_q, pend0_d;
	logic [7:0]   pend1_q, pend1_d;
	logic [7:0]   pend2_q, pend2_d;
	logic [7:0]   byte_q, byte_d;
	logic [7:0]   term_q, term_d;

	logic            byte_go;
	logic [7:0]      b_sel;
	logic [2:0]      b_len;
	logic            lk_req;
	logic [CP_W-1:0] lk_cp;

	assign b_len = lead_len(b_sel);

	// sequencer, utf8 decode and command issue
	always_comb begin
		state_d  = state_q;
		open_d   = open_q;
		seq_d    = seq_q;
		cnt_d    = cnt_q;
		pend0_d  = pend0_q;
		pend1_d  = pend1_q;
		pend2_d  = pend2_q;
		byte_d   = byte_q;
		term_d   = term_q;
		in_ready = 1'b0;
		push     = 1'b0;
		push_cmd = '0;
		byte_go  = 1'b0;
		b_sel    = byte_q;
		lk_req   = 1'b0;
		lk_cp    = '0;

		case (state_q)
			FS_IDLE: begin
				in_ready = map_ready && !q_full;
				if (in_valid && in_ready) begin
					case (in_item.op)
						OP_LOAD: begin
							if (32'(in_item.map_code_point) < MAP_LIMIT &&
								{1'b0, in_item.map_symbol_id} < SYM_LIMIT) begin
								push          = 1'b1;
								push_cmd.kind = CMD_LOAD;
								push_cmd.addr = CMD_ADDR_W'(in_item.map_code_point);
								push_cmd.sym  = in_item.map_symbol_id;
							end
						end
						OP_BYTE: begin
							if (!open_q) begin
								// leading pad first, the byte follows from FS_BYTE once the queue has room
								push          = 1'b1;
								push_cmd.kind = CMD_PAD;
								open_d        = 1'b1;
								byte_d        = in_item.text_byte;
								state_d       = FS_BYTE;
							end else begin
								byte_go = 1'b1;
								b_sel   = in_item.text_byte;
							end
						end
						OP_FINISH: begin
							term_d = in_item.terminator_char;
							if (!open_q) begin
								push          = 1'b1;
								push_cmd.kind = CMD_PAD;
							end
							state_d = (seq_q != '0) ? FS_FIN1 : FS_TERM;
						end
						default: ;
					endcase
				end
			end
			FS_BYTE: begin
				if (!q_full) begin
					byte_go = 1'b1;
					state_d = FS_IDLE;
				end
			end
			FS_FIN1: begin
				// re-decode the bytes buffered after a truncated lead
				if (!q_full) begin
					state_d = FS_TERM;
					if (cnt_q >= 2'd2) begin
						if (lead_len(pend1_q) == 3'd1) begin
							lk_req  = 1'b1;
							lk_cp   = CP_W'(pend1_q);
							state_d = FS_FIN2;
						end else if (lead_len(pend1_q) == 3'd2 && cnt_q == 2'd3) begin
							lk_req = 1'b1;
							lk_cp  = cp_from_seq(3'd2, pend1_q, 8'd0, 8'd0, pend2_q);
						end else begin
							state_d = FS_FIN2;
						end
					end
				end
			end
			FS_FIN2: begin
				if (!q_full) begin
					if (cnt_q == 2'd3 && lead_len(pend2_q) == 3'd1) begin
						lk_req = 1'b1;
						lk_cp  = CP_W'(pend2_q);
					end
					state_d = FS_TERM;
				end
			end
			FS_TERM: begin
				// terminators beyond the map are never mapped
				if (!q_full) begin
					if (term_q != 8'd0 && 32'(term_q) < MAP_LIMIT) begin
						push          = 1'b1;
						push_cmd.kind = CMD_TERM;
						push_cmd.addr = CMD_ADDR_W'(term_q);
					end
					state_d = FS_NL;
				end
			end
			FS_NL: begin
				if (!q_full) begin
					push          = 1'b1;
					push_cmd.kind = CMD_NL;
					state_d       = FS_END;
				end
			end
			FS_END: begin
				if (!q_full) begin
					push          = 1'b1;
					push_cmd.kind = CMD_END;
					open_d        = 1'b0;
					seq_d         = '0;
					cnt_d         = '0;
					state_d       = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase

		// one sentence byte into the decoder
		if (byte_go) begin
			if (seq_q == '0) begin
				if (b_len == 3'd1) begin
					lk_req = 1'b1;
					lk_cp  = CP_W'(b_sel);
				end else if (b_len != 3'd0) begin
					pend0_d = b_sel;
					cnt_d   = 2'd1;
					seq_d   = b_len;
				end
			end else if ({1'b0, cnt_q} == seq_q - 3'd1) begin
				lk_req = 1'b1;
				lk_cp  = cp_from_seq(seq_q, pend0_q, pend1_q, pend2_q, b_sel);
				cnt_d  = '0;
				seq_d  = '0;
			end else begin
				if (cnt_q == 2'd1) begin
					pend1_d = b_sel;
				end else begin
					pend2_d = b_sel;
				end
				cnt_d = cnt_q + 2'd1;
			end
		end

		// code points beyond the map are never mapped
		if (lk_req && 32'(lk_cp) < MAP_LIMIT) begin
			push          = 1'b1;
			push_cmd.kind = CMD_LOOKUP;
			push_cmd.addr = lk_cp[CMD_ADDR_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			open_q  <= 1'b0;
			seq_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			open_q  <= open_d;
			seq_q   <= seq_d;
			cnt_q   <= cnt_d;
		end
	end

	// buffered bytes
	always_ff @(posedge clk) begin
		pend0_q <= pend0_d;
		pend1_q <= pend1_d;
		pend2_q <= pend2_d;
		byte_q  <= byte_d;
		term_q  <= term_d;
	end
endmodule

FILE: hdl/u8tok_back.sv
// back end: symbol map, lookups, token counting and result register
module u8tok_back #(
	parameter int MAP_ENTRIES = u8tok_pkg::DEF_MAP_ENTRIES,
	parameter int TOKEN_CAP   = u8tok_pkg::DEF_TOKEN_CAP
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                map_ready,
	input  u8tok_pkg::cmd_t     head,
	input  logic                q_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output u8tok_pkg::tok_out_t out_item
);
	import u8tok_pkg::*;

	localparam int AW = $clog2(MAP_ENTRIES);
	localparam int TW = $clog2(TOKEN_CAP + 1);

	logic               clearing_q;
	logic [AW-1:0]      clr_addr_q;
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               out_valid_q;
	tok_out_t           out_item_q;
	logic [TW-1:0]      tokens_q, tokens_d;
	logic [ENTRY_W-1:0] last_q, last_d;

	logic               advance;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] entry;
	logic               mapped;
	logic               room;
	logic               emit;
	tok_out_t           emit_item;

	assign map_ready = !clearing_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// pipeline moves when the result register is free or being taken
	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && !q_empty && !clearing_q;

	// map writes: clearing pass after reset, then loads
	assign ram_we    = clearing_q || (pop && head.kind == CMD_LOAD);
	assign ram_waddr = clearing_q ? clr_addr_q : head.addr[AW-1:0];
	assign ram_wdata = clearing_q ? NO_TOKEN : {1'b0, head.sym};

	u8tok_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAP_ENTRIES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(head.addr[AW-1:0]),
		.rdata(entry)
	);

	assign mapped = !entry[ENTRY_W-1];
	assign room   = tokens_q < TW'(TOKEN_CAP - 3);

	// token decision for the command in stage 1
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		tokens_d  = tokens_q;
		last_d    = last_q;
		if (valid_s1) begin
			case (cmd_s1.kind)
				CMD_PAD: begin
					emit               = 1'b1;
					emit_item.token_id = PAD_ID;
					tokens_d           = TW'(1);
					last_d             = NO_TOKEN;
				end
				CMD_LOOKUP: begin
					if (mapped && room) begin
						emit               = 1'b1;
						emit_item.token_id = entry[7:0];
						tokens_d           = tokens_q + 1'b1;
						last_d             = entry;
					end
				end
				CMD_TERM: begin
					// terminator is dropped when it repeats the last id
					if (mapped && room && entry != last_q) begin
						emit               = 1'b1;
						emit_item.token_id = entry[7:0];
						tokens_d           = tokens_q + 1'b1;
						last_d             = entry;
					end
				end
				CMD_NL: begin
					emit               = 1'b1;
					emit_item.token_id = NEWLINE_ID;
				end
				CMD_END: begin
					emit                   = 1'b1;
					emit_item.token_id     = PAD_ID;
					emit_item.sentence_end = 1'b1;
					tokens_d               = '0;
					last_d                 = NO_TOKEN;
				end
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			tokens_q    <= '0;
			last_q      <= NO_TOKEN;
		end else begin
			if (clearing_q) begin
				if (clr_addr_q == AW'(MAP_ENTRIES - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (advance) begin
				valid_s1    <= pop && head.kind != CMD_LOAD;
				out_valid_q <= emit;
				tokens_q    <= tokens_d;
				last_q      <= last_d;
			end
		end
	end

	// stage 1 command and result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1     <= head;
			out_item_q <= emit_item;
		end
	end
endmodule

FILE: hdl/utf8_phoneme_tokenizer.sv
// top level: utf8 phoneme tokenizer with decoupled front, queue and back
// a byte's command passes a queue slot, the map read and the result register; one byte or
// map load is taken per cycle while the queue has room, a sentence's first byte after its
// leading pad; finish holds input through FS_FIN1 and FS_FIN2 if bytes are pending, then
// FS_TERM, FS_NL and FS_END; reset: the map clear pass writes one entry per cycle to every
// map entry (8960 by default), no item taken until it ends; sentence state resets at once
module utf8_phoneme_tokenizer #(
	parameter int MAP_ENTRIES  = u8tok_pkg::DEF_MAP_ENTRIES,
	parameter int TOKEN_CAP    = u8tok_pkg::DEF_TOKEN_CAP,
	parameter int SYMBOL_COUNT = u8tok_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  u8tok_pkg::tok_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output u8tok_pkg::tok_out_t out_item
);
	import u8tok_pkg::*;

	logic map_ready;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t head;
	logic q_empty;

	// input side
	u8tok_front #(
		.MAP_ENTRIES (MAP_ENTRIES),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.map_ready(map_ready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	// command queue
	u8tok_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty)
	);

	// output side
	u8tok_back #(
		.MAP_ENTRIES(MAP_ENTRIES),
		.TOKEN_CAP  (TOKEN_CAP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.map_ready(map_ready),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);
endmodule
